### hw/rtl/csc_pkg.sv
// csc_pkg: shared types and constants for the color space converter
// no dependencies
package csc_pkg;

	localparam int NUM_W   = 25;
	localparam int DEN_W   = 15;
	localparam int QUO_W   = 16;
	localparam int LANES   = 4;

	typedef enum logic [2:0] {
		MODE_NORM = 3'd0,
		MODE_HSV  = 3'd1,
		MODE_CMYK = 3'd2,
		MODE_RGB  = 3'd3,
		MODE_GRAY = 3'd4
	} mode_t;

	// operands of one pixel handed to the divider lanes
	typedef struct packed {
		logic [LANES-1:0][NUM_W-1:0] num;
		logic [LANES-1:0][DEN_W-1:0] den;
		logic                        status;
	} oper_t;

endpackage

### hw/rtl/color_space_converter_unit.sv
// color_space_converter_unit: top level, operand stages and four divider lanes
// depends on csc_pkg, csc_prep, csc_div_lane
//
// channel   signals                                         dir
// input     in_valid in_ready req_type red green blue        in
//           cyan magenta yellow key_black
// output    out_valid out_ready out_first out_second          out
//           out_third out_fourth status
//
// one pixel per cycle while out_ready does not stall; two operand stages and sixteen
// divider stages, one quotient bit per stage in each of four lanes
// reset clears only the stage valid bits
// each full stage holds while the next one is full and stalled, so bubbles close up
module color_space_converter_unit import csc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [6:0]  cyan,
	input  logic [6:0]  magenta,
	input  logic [6:0]  yellow,
	input  logic [6:0]  key_black,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_first,
	output logic [13:0] out_second,
	output logic [13:0] out_third,
	output logic [13:0] out_fourth,
	output logic        status
);

	localparam int STAGES = QUO_W + 2;

	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] en;
	logic [QUO_W-1:0]  st_s;
	oper_t             oper;
	logic [QUO_W-1:0]  quo [LANES];

	always_comb begin
		en[STAGES-1] = !vld_q[STAGES-1] || out_ready;
		for (int i = STAGES - 2; i >= 0; i--) en[i] = !vld_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_valid;
			for (int i = 1; i < STAGES; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	csc_prep u_prep (
		.clk       (clk),
		.en_s1     (en[0]),
		.en_s2     (en[1]),
		.req_type  (req_type),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.cyan      (cyan),
		.magenta   (magenta),
		.yellow    (yellow),
		.key_black (key_black),
		.oper      (oper)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		csc_div_lane u_lane (
			.clk (clk),
			.en  (en[STAGES-1:2]),
			.num (oper.num[l]),
			.den (oper.den[l]),
			.quo (quo[l])
		);
	end

	// status rides alongside the divider stages
	always_ff @(posedge clk) begin
		if (en[2]) st_s[0] <= oper.status;
		for (int j = 1; j < QUO_W; j++) begin
			if (en[j+2]) st_s[j] <= st_s[j-1];
		end
	end

	assign in_ready   = en[0];
	assign out_valid  = vld_q[STAGES-1];
	assign out_first  = quo[0];
	assign out_second = quo[1][13:0];
	assign out_third  = quo[2][13:0];
	assign out_fourth = quo[3][13:0];
	assign status     = st_s[QUO_W-1];

endmodule

### hw/rtl/csc_prep.sv
// csc_prep: two pipeline stages, channel extremes then divider operands
// depends on csc_pkg
module csc_prep import csc_pkg::*; (
	input  logic        clk,
	input  logic        en_s1,
	input  logic        en_s2,
	input  logic [2:0]  req_type,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [6:0]  cyan,
	input  logic [6:0]  magenta,
	input  logic [6:0]  yellow,
	input  logic [6:0]  key_black,
	output oper_t       oper
);

	logic [2:0] mode_s1;
	logic [7:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	logic [6:0] ci_s1, mi_s1, yi_s1, k_s1;
	logic [7:0] mx_c, mn_c;
	oper_t      oper_s2, oper_c;

	function automatic logic [6:0] inv_pct(input logic [6:0] v);
		return (v > 7'd100) ? 7'd0 : 7'(7'd100 - v);
	endfunction

	always_comb begin
		mx_c = red;
		mn_c = red;
		if (green > mx_c) mx_c = green;
		if (blue > mx_c) mx_c = blue;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c) mn_c = blue;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1 <= req_type;
			r_s1    <= red;
			g_s1    <= green;
			b_s1    <= blue;
			mx_s1   <= mx_c;
			mn_s1   <= mn_c;
			ci_s1   <= inv_pct(cyan);
			mi_s1   <= inv_pct(magenta);
			yi_s1   <= inv_pct(yellow);
			k_s1    <= inv_pct(key_black);
		end
	end

	logic [NUM_W-1:0] r_w, g_w, b_w, mx_w, d_w, sum_w, hue_w;

	always_comb begin
		r_w   = NUM_W'(r_s1);
		g_w   = NUM_W'(g_s1);
		b_w   = NUM_W'(b_s1);
		mx_w  = NUM_W'(mx_s1);
		d_w   = NUM_W'(mx_s1 - mn_s1);
		sum_w = r_w + g_w + b_w;
		if (r_s1 == mx_s1) begin
			if (g_s1 >= b_s1) hue_w = NUM_W'(25'd6000 * (g_w - b_w));
			else hue_w = NUM_W'(25'd36000 * d_w - 25'd6000 * (b_w - g_w));
		end else if (g_s1 == mx_s1) begin
			hue_w = NUM_W'(25'd12000 * d_w + 25'd6000 * b_w - 25'd6000 * r_w);
		end else begin
			hue_w = NUM_W'(25'd24000 * d_w + 25'd6000 * r_w - 25'd6000 * g_w);
		end

		// zero numerator over a divisor of two gives a zero quotient
		for (int i = 0; i < LANES; i++) begin
			oper_c.num[i] = '0;
			oper_c.den[i] = DEN_W'(2);
		end
		oper_c.status = 1'b0;

		case (mode_s1)
			MODE_NORM: begin
				if (sum_w == '0) begin
					oper_c.status = 1'b1;
				end else begin
					oper_c.num[0] = NUM_W'(r_w * 25'd200 + sum_w);
					oper_c.num[1] = NUM_W'(g_w * 25'd200 + sum_w);
					oper_c.num[2] = NUM_W'(b_w * 25'd200 + sum_w);
					for (int i = 0; i < 3; i++) oper_c.den[i] = DEN_W'(sum_w << 1);
				end
			end
			MODE_HSV: begin
				oper_c.num[2] = NUM_W'(mx_w * 25'd20000 + 25'd255);
				oper_c.den[2] = DEN_W'(510);
				if (mx_s1 != 8'd0) begin
					oper_c.num[1] = NUM_W'(d_w * 25'd20000 + mx_w);
					oper_c.den[1] = DEN_W'(mx_w << 1);
				end
				if (d_w == '0) begin
					oper_c.status = 1'b1;
				end else begin
					oper_c.num[0] = NUM_W'((hue_w << 1) + d_w);
					oper_c.den[0] = DEN_W'(d_w << 1);
				end
			end
			MODE_CMYK: begin
				oper_c.num[3] = NUM_W'((25'd255 - mx_w) * 25'd20000 + 25'd255);
				oper_c.den[3] = DEN_W'(510);
				if (mx_s1 == 8'd0) begin
					oper_c.status = 1'b1;
				end else begin
					oper_c.num[0] = NUM_W'((mx_w - r_w) * 25'd20000 + mx_w);
					oper_c.num[1] = NUM_W'((mx_w - g_w) * 25'd20000 + mx_w);
					oper_c.num[2] = NUM_W'((mx_w - b_w) * 25'd20000 + mx_w);
					for (int i = 0; i < 3; i++) oper_c.den[i] = DEN_W'(mx_w << 1);
				end
			end
			MODE_RGB: begin
				oper_c.num[0] = NUM_W'(25'd510 * (NUM_W'(ci_s1) * NUM_W'(k_s1)) + 25'd10000);
				oper_c.num[1] = NUM_W'(25'd510 * (NUM_W'(mi_s1) * NUM_W'(k_s1)) + 25'd10000);
				oper_c.num[2] = NUM_W'(25'd510 * (NUM_W'(yi_s1) * NUM_W'(k_s1)) + 25'd10000);
				for (int i = 0; i < 3; i++) oper_c.den[i] = DEN_W'(20000);
			end
			MODE_GRAY: begin
				oper_c.num[0] = NUM_W'((25'd299 * r_w + 25'd587 * g_w + 25'd114 * b_w) * 25'd2
					+ 25'd1000);
				oper_c.den[0] = DEN_W'(2000);
			end
			default: begin
				oper_c.status = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2) oper_s2 <= oper_c;
	end

	assign oper = oper_s2;

endmodule

### hw/rtl/csc_div_lane.sv
// csc_div_lane: restoring divider, one quotient bit per pipeline stage
// depends on csc_pkg
module csc_div_lane import csc_pkg::*; (
	input  logic                 clk,
	input  logic [QUO_W-1:0]     en,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	output logic [QUO_W-1:0]     quo
);

	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [NUM_W-1:0] num_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];

	for (genvar j = 0; j < QUO_W; j++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] num_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [DEN_W:0]   trial;
		logic             take;

		if (j == 0) begin : g_first
			// top numerator bits are below the divisor since the quotient fits
			assign rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
			assign num_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign num_in = num_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		assign trial = {rem_in, num_in[QUO_W-1-j]};
		assign take  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j] <= take ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
				num_s[j] <= num_in;
				den_s[j] <= den_in;
				quo_s[j] <= {quo_in[QUO_W-2:0], take};
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule
